// ----- rtl/rvdec_pkg.sv -----
`timescale 1ns / 1ps

package rvdec_pkg;

    localparam int unsigned OP_W   = 6;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned IMM_W  = 32;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 4;

    // output tdata: operation, dest_reg, src_reg_a, src_reg_b, immediate, zero pad
    localparam int unsigned RES_W      = OP_W + 3 * REG_W + IMM_W;
    localparam int unsigned RES_BYTE_W = ((RES_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [REG_W-1:0]  t_reg;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [2:0]        t_funct3;

    localparam t_op OP_ADD    = 6'd0;
    localparam t_op OP_SUB    = 6'd1;
    localparam t_op OP_XOR    = 6'd2;
    localparam t_op OP_OR     = 6'd3;
    localparam t_op OP_AND    = 6'd4;
    localparam t_op OP_SLL    = 6'd5;
    localparam t_op OP_SRL    = 6'd6;
    localparam t_op OP_SRA    = 6'd7;
    localparam t_op OP_SLT    = 6'd8;
    localparam t_op OP_SLTU   = 6'd9;
    localparam t_op OP_ADDI   = 6'd10;
    localparam t_op OP_XORI   = 6'd11;
    localparam t_op OP_ORI    = 6'd12;
    localparam t_op OP_ANDI   = 6'd13;
    localparam t_op OP_SLLI   = 6'd14;
    localparam t_op OP_SRLI   = 6'd15;
    localparam t_op OP_SRAI   = 6'd16;
    localparam t_op OP_SLTI   = 6'd17;
    localparam t_op OP_SLTIU  = 6'd18;
    localparam t_op OP_LB     = 6'd19;
    localparam t_op OP_LH     = 6'd20;
    localparam t_op OP_LW     = 6'd21;
    localparam t_op OP_LBU    = 6'd22;
    localparam t_op OP_LHU    = 6'd23;
    localparam t_op OP_JALR   = 6'd24;
    localparam t_op OP_ECALL  = 6'd25;
    localparam t_op OP_EBREAK = 6'd26;
    localparam t_op OP_SB     = 6'd27;
    localparam t_op OP_SH     = 6'd28;
    localparam t_op OP_SW     = 6'd29;
    localparam t_op OP_BEQ    = 6'd30;
    localparam t_op OP_BNE    = 6'd31;
    localparam t_op OP_BLT    = 6'd32;
    localparam t_op OP_BGE    = 6'd33;
    localparam t_op OP_BLTU   = 6'd34;
    localparam t_op OP_BGEU   = 6'd35;
    localparam t_op OP_JAL    = 6'd36;
    localparam t_op OP_LUI    = 6'd37;
    localparam t_op OP_AUIPC  = 6'd38;
    localparam t_op OP_NOP    = 6'd39;

    localparam t_kind KIND_R      = 4'd0;
    localparam t_kind KIND_I_ALU  = 4'd1;
    localparam t_kind KIND_I_LOAD = 4'd2;
    localparam t_kind KIND_JALR   = 4'd3;
    localparam t_kind KIND_SYSTEM = 4'd4;
    localparam t_kind KIND_S      = 4'd5;
    localparam t_kind KIND_B      = 4'd6;
    localparam t_kind KIND_LUI    = 4'd7;
    localparam t_kind KIND_AUIPC  = 4'd8;
    localparam t_kind KIND_J      = 4'd9;

    localparam t_funct3 F3_0 = 3'd0;
    localparam t_funct3 F3_1 = 3'd1;
    localparam t_funct3 F3_2 = 3'd2;
    localparam t_funct3 F3_3 = 3'd3;
    localparam t_funct3 F3_4 = 3'd4;
    localparam t_funct3 F3_5 = 3'd5;
    localparam t_funct3 F3_6 = 3'd6;
    localparam t_funct3 F3_7 = 3'd7;

    typedef struct packed {
        logic [IMM_W-1:0] immediate;
        t_reg             src_reg_b;
        t_reg             src_reg_a;
        t_reg             dest_reg;
        t_op              operation;
    } t_dec_result;

endpackage

// ----- rtl/rvdec_decode.sv -----
`timescale 1ns / 1ps

module rvdec_decode (
    input  logic [rvdec_pkg::WORD_W-1:0] i_instr_word,
    input  rvdec_pkg::t_kind             i_kind,
    output rvdec_pkg::t_dec_result       o_result
);

    logic [4:0]  w_rd;
    logic [4:0]  w_rs1;
    logic [4:0]  w_rs2;
    logic [2:0]  w_f3;
    logic        w_f7_zero;
    logic [31:0] w_imm_i;
    logic [31:0] w_imm_s;
    logic [31:0] w_imm_b;
    logic [31:0] w_imm_u;
    logic [31:0] w_imm_j;

    assign w_rd      = i_instr_word[11:7];
    assign w_f3      = i_instr_word[14:12];
    assign w_rs1     = i_instr_word[19:15];
    assign w_rs2     = i_instr_word[24:20];
    assign w_f7_zero = (i_instr_word[31:25] == 7'd0);

    assign w_imm_i = {{20{i_instr_word[31]}}, i_instr_word[31:20]};
    assign w_imm_s = {{20{i_instr_word[31]}}, i_instr_word[31:25], i_instr_word[11:7]};
    assign w_imm_b = {{20{i_instr_word[31]}}, i_instr_word[7], i_instr_word[30:25],
                      i_instr_word[11:8], 1'b0};
    // upper immediate is kept unshifted
    assign w_imm_u = {12'd0, i_instr_word[31:12]};
    assign w_imm_j = {{12{i_instr_word[31]}}, i_instr_word[19:12], i_instr_word[20],
                      i_instr_word[30:21], 1'b0};

    always_comb begin
        o_result = '0;
        o_result.operation = rvdec_pkg::OP_NOP;
        unique case (i_kind)
            rvdec_pkg::KIND_R: begin
                if (w_f7_zero) begin
                    unique case (w_f3)
                        rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_ADD;
                        rvdec_pkg::F3_1: o_result.operation = rvdec_pkg::OP_SLL;
                        rvdec_pkg::F3_2: o_result.operation = rvdec_pkg::OP_SLT;
                        rvdec_pkg::F3_3: o_result.operation = rvdec_pkg::OP_SLTU;
                        rvdec_pkg::F3_4: o_result.operation = rvdec_pkg::OP_XOR;
                        rvdec_pkg::F3_5: o_result.operation = rvdec_pkg::OP_SRL;
                        rvdec_pkg::F3_6: o_result.operation = rvdec_pkg::OP_OR;
                        default:         o_result.operation = rvdec_pkg::OP_AND;
                    endcase
                end else begin
                    unique case (w_f3)
                        rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_SUB;
                        rvdec_pkg::F3_5: o_result.operation = rvdec_pkg::OP_SRA;
                        default:         o_result.operation = rvdec_pkg::OP_NOP;
                    endcase
                end
                o_result.dest_reg  = w_rd;
                o_result.src_reg_a = w_rs1;
                o_result.src_reg_b = w_rs2;
            end
            rvdec_pkg::KIND_I_ALU: begin
                unique case (w_f3)
                    rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_ADDI;
                    rvdec_pkg::F3_1: o_result.operation = rvdec_pkg::OP_SLLI;
                    rvdec_pkg::F3_2: o_result.operation = rvdec_pkg::OP_SLTI;
                    rvdec_pkg::F3_3: o_result.operation = rvdec_pkg::OP_SLTIU;
                    rvdec_pkg::F3_4: o_result.operation = rvdec_pkg::OP_XORI;
                    rvdec_pkg::F3_5: o_result.operation = w_f7_zero ? rvdec_pkg::OP_SRLI
                                                                    : rvdec_pkg::OP_SRAI;
                    rvdec_pkg::F3_6: o_result.operation = rvdec_pkg::OP_ORI;
                    default:         o_result.operation = rvdec_pkg::OP_ANDI;
                endcase
                o_result.dest_reg  = w_rd;
                o_result.src_reg_a = w_rs1;
                o_result.immediate = w_imm_i;
            end
            rvdec_pkg::KIND_I_LOAD: begin
                unique case (w_f3)
                    rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_LB;
                    rvdec_pkg::F3_1: o_result.operation = rvdec_pkg::OP_LH;
                    rvdec_pkg::F3_2: o_result.operation = rvdec_pkg::OP_LW;
                    rvdec_pkg::F3_4: o_result.operation = rvdec_pkg::OP_LBU;
                    rvdec_pkg::F3_5: o_result.operation = rvdec_pkg::OP_LHU;
                    default:         o_result.operation = rvdec_pkg::OP_NOP;
                endcase
                o_result.dest_reg  = w_rd;
                o_result.src_reg_a = w_rs1;
                o_result.immediate = w_imm_i;
            end
            rvdec_pkg::KIND_JALR: begin
                o_result.operation = rvdec_pkg::OP_JALR;
                o_result.dest_reg  = w_rd;
                o_result.src_reg_a = w_rs1;
                o_result.immediate = w_imm_i;
            end
            rvdec_pkg::KIND_SYSTEM: begin
                o_result.operation = (i_instr_word[31:20] == 12'd0) ? rvdec_pkg::OP_ECALL
                                                                    : rvdec_pkg::OP_EBREAK;
                o_result.dest_reg  = w_rd;
                o_result.src_reg_a = w_rs1;
                o_result.immediate = w_imm_i;
            end
            rvdec_pkg::KIND_S: begin
                unique case (w_f3)
                    rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_SB;
                    rvdec_pkg::F3_1: o_result.operation = rvdec_pkg::OP_SH;
                    default:         o_result.operation = rvdec_pkg::OP_SW;
                endcase
                o_result.src_reg_a = w_rs1;
                o_result.src_reg_b = w_rs2;
                o_result.immediate = w_imm_s;
            end
            rvdec_pkg::KIND_B: begin
                unique case (w_f3)
                    rvdec_pkg::F3_0: o_result.operation = rvdec_pkg::OP_BEQ;
                    rvdec_pkg::F3_1: o_result.operation = rvdec_pkg::OP_BNE;
                    rvdec_pkg::F3_4: o_result.operation = rvdec_pkg::OP_BLT;
                    rvdec_pkg::F3_5: o_result.operation = rvdec_pkg::OP_BGE;
                    rvdec_pkg::F3_6: o_result.operation = rvdec_pkg::OP_BLTU;
                    rvdec_pkg::F3_7: o_result.operation = rvdec_pkg::OP_BGEU;
                    default:         o_result.operation = rvdec_pkg::OP_NOP;
                endcase
                o_result.src_reg_a = w_rs1;
                o_result.src_reg_b = w_rs2;
                o_result.immediate = w_imm_b;
            end
            rvdec_pkg::KIND_LUI: begin
                o_result.operation = rvdec_pkg::OP_LUI;
                o_result.dest_reg  = w_rd;
                o_result.immediate = w_imm_u;
            end
            rvdec_pkg::KIND_AUIPC: begin
                o_result.operation = rvdec_pkg::OP_AUIPC;
                o_result.dest_reg  = w_rd;
                o_result.immediate = w_imm_u;
            end
            rvdec_pkg::KIND_J: begin
                o_result.operation = rvdec_pkg::OP_JAL;
                o_result.dest_reg  = w_rd;
                o_result.immediate = w_imm_j;
            end
            default: begin
                o_result = '0;
                o_result.operation = rvdec_pkg::OP_NOP;
            end
        endcase
    end

endmodule

// ----- rtl/rv32i_instruction_decoder_unit.sv -----
`timescale 1ns / 1ps
// an accepted input word passes the input register, then the result register, to its result word on the master side
// throughput: one word per cycle while the master side accepts; input register, decode logic, result register
// backpressure on the master side stalls both stages; each stage refills as soon as it drains
// reset: synchronous, active low, clears both stage valid flags; payload is not reset

module rv32i_instruction_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rvdec_pkg::WORD_W-1:0]        s_axis_tdata,  // instr_word
    input  logic [rvdec_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // operation, dest_reg, src_reg_a, src_reg_b, immediate, zero pad
    output logic [rvdec_pkg::RES_BYTE_W-1:0]    m_axis_tdata
);

    logic                         r_in_valid;
    logic [rvdec_pkg::WORD_W-1:0] r_instr_word;
    rvdec_pkg::t_kind             r_kind;
    logic                         r_out_valid;
    rvdec_pkg::t_dec_result       r_result;
    rvdec_pkg::t_dec_result       w_result;
    logic                         w_out_ready;
    logic                         w_in_ready;
    logic                         n_in_valid;
    logic                         n_out_valid;

    assign w_out_ready = !r_out_valid || m_axis_tready;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign n_in_valid  = s_axis_tvalid || (r_in_valid && !w_out_ready);
    assign n_out_valid = r_in_valid || (r_out_valid && !m_axis_tready);

    rvdec_decode u_decode (
        .i_instr_word (r_instr_word),
        .i_kind       (r_kind),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && s_axis_tvalid) begin
            r_instr_word <= s_axis_tdata;
            r_kind       <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_in_valid) begin
            r_result <= w_result;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rvdec_pkg::RES_BYTE_W - rvdec_pkg::RES_W){1'b0}}, r_result};

endmodule

// ----- rtl/rvdec_checker.sv -----
`timescale 1ns / 1ps

module rvdec_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rvdec_pkg::RES_BYTE_W-1:0] m_axis_tdata
);

    localparam int unsigned OP_LO  = 0;
    localparam int unsigned RD_LO  = rvdec_pkg::OP_W;

    logic [rvdec_pkg::OP_W-1:0]  w_op;
    logic [rvdec_pkg::REG_W-1:0] w_rd;

    assign w_op = m_axis_tdata[OP_LO +: rvdec_pkg::OP_W];
    assign w_rd = m_axis_tdata[RD_LO +: rvdec_pkg::REG_W];

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // empty result register never blocks the input side
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a word accepted with the output free shows up after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result word missing after accepted input");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_op <= rvdec_pkg::OP_NOP)
        else $error("operation number out of range");

    // stores and branches carry no rd
    a_no_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_op >= rvdec_pkg::OP_SB && w_op <= rvdec_pkg::OP_BGEU
        |-> w_rd == '0)
        else $error("store or branch with nonzero rd");

endmodule

bind rv32i_instruction_decoder_unit rvdec_checker u_rvdec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
